### rtl/sbf_pkg.sv
package sbf_pkg;

   // register indexes of the configuration port
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_SPRING_CONSTANT = 2'd0;
   localparam csr_index_type CSR_REST_LENGTH     = 2'd1;
   localparam csr_index_type CSR_BUNGEE_MODE     = 2'd2;

   // per-axis magnitude of the difference vector and its sign
   typedef struct packed {
      logic [2:0][32:0] mag;
      logic [2:0]       dneg;
   } axis_type;

   // one step of the bit-serial square root
   typedef struct packed {
      logic [65:0] rem;
      logic [32:0] root;
      axis_type    ax;
   } root_stage_type;

   // length, stretch and flags
   typedef struct packed {
      logic [32:0] len;
      logic [32:0] emag;
      logic        eneg;
      logic        slack;
      logic        zero_len;
      axis_type    ax;
   } len_stage_type;

   typedef struct packed {
      logic [47:0]   p_lo;
      logic [46:0]   p_hi;
      len_stage_type ls;
   } kmul_stage_type;

   typedef struct packed {
      logic [63:0]   ke;
      len_stage_type ls;
   } ke_stage_type;

   typedef struct packed {
      logic [2:0][64:0] p0;
      logic [2:0][64:0] p1;
      logic [32:0]      len;
      logic [2:0]       neg;
      logic             slack;
      logic             zero_len;
   } nmul_stage_type;

   typedef struct packed {
      logic [2:0][80:0] num;
      logic [32:0]      len;
      logic [2:0]       neg;
      logic             slack;
      logic             zero_len;
   } num_stage_type;

   // one step of the restoring divider, three axes side by side
   typedef struct packed {
      logic [32:0]      len;
      logic [2:0][32:0] rem;
      logic [2:0][31:0] qn;
      logic [2:0]       over;
      logic [2:0]       neg;
      logic             slack;
      logic             zero_len;
   } div_stage_type;

endpackage

### rtl/spring_bungee_force.sv
// Each input beat flows through the pipeline and output register to rsp_*.
// Throughput: one beat per cycle; the whole pipeline holds only while its last
// stage is full and the output register is full and stalled.
// Reset (synchronous, active high): clears all valid bits, empties the pipeline
// and sets spring_constant = 1.0, rest_length = 0, bungee_mode = 0.
module spring_bungee_force
   import sbf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // input channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_particle_x,
   input  logic signed [31:0]  req_particle_y,
   input  logic signed [31:0]  req_particle_z,
   input  logic signed [31:0]  req_end_x,
   input  logic signed [31:0]  req_end_y,
   input  logic signed [31:0]  req_end_z,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_force_x,
   output logic signed [31:0]  rsp_force_y,
   output logic signed [31:0]  rsp_force_z,
   output logic                rsp_applied,
   // configuration port
   input  logic                csr_valid,
   output logic                csr_ready,
   input  csr_index_type       csr_index,
   input  logic [31:0]         csr_wdata
);

   // Stage map of the valid shift line:
   //   0        difference vector
   //   1        magnitudes and squares
   //   2        sum of squares (square root input)
   //   3..35    33 square root steps, one result bit each
   //   36       length, stretch, slack and zero-length flags
   //   37..40   k*|e| in two halves, then k*|e|*|d| in two halves per axis
   //   41       divider setup and overflow check
   //   42..73   32 divider steps, one quotient bit each
   localparam int NStage   = 74;
   localparam int RootBase = 2;
   localparam int DivBase  = 41;

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [30:0] spring_k_ff;
   logic [30:0] rest_ff;
   logic        bungee_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         spring_k_ff <= 31'd65536;
         rest_ff     <= '0;
         bungee_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SPRING_CONSTANT: spring_k_ff <= csr_wdata[30:0];
            CSR_REST_LENGTH:     rest_ff     <= csr_wdata[30:0];
            CSR_BUNGEE_MODE:     bungee_ff   <= csr_wdata[0];
            default:             ;  // drop writes beyond the register list
         endcase
      end
   end

   // ---------------------------------------------------------------
   // flow control
   // ---------------------------------------------------------------
   logic [NStage-1:0] v_ff;
   logic              rsp_valid_ff;
   logic              out_take;
   logic              en;

   // the output register takes a beat when empty or being drained
   assign out_take  = !rsp_valid_ff || !rsp_stall;
   // advance the pipeline unless the last stage has nowhere to go
   assign en        = out_take || !v_ff[NStage-1];
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NStage-2:0], req_valid};
      end
   end

   // ---------------------------------------------------------------
   // stage 0: difference vector d = P - E, 33 bits signed
   // ---------------------------------------------------------------
   logic signed [2:0][32:0] d_ff;
   logic signed [2:0][32:0] d_in;

   always_comb begin
      d_in[0] = {req_particle_x[31], req_particle_x} - {req_end_x[31], req_end_x};
      d_in[1] = {req_particle_y[31], req_particle_y} - {req_end_y[31], req_end_y};
      d_in[2] = {req_particle_z[31], req_particle_z} - {req_end_z[31], req_end_z};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 1: magnitudes and their squares
   // ---------------------------------------------------------------
   axis_type          ax_ff;
   axis_type          ax_in;
   logic [2:0][65:0]  sq_ff;
   logic [2:0][65:0]  sq_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ax_in.dneg[i] = d_ff[i][32];
         ax_in.mag[i]  = d_ff[i][32] ? (~d_ff[i] + 33'd1) : d_ff[i];
         sq_in[i]      = 66'(ax_in.mag[i]) * 66'(ax_in.mag[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff <= ax_in;
         sq_ff <= sq_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 2 and square root: one root bit per stage, MSB first.
   // rem tracks S - root^2; a bit is kept when the growth of the
   // square, (root << (b+1)) + 2^(2b), still fits in rem.
   // ---------------------------------------------------------------
   root_stage_type root_ff [34];
   root_stage_type root_in [33];
   root_stage_type root_head_in;

   always_comb begin
      root_head_in.rem  = sq_ff[0] + sq_ff[1] + sq_ff[2];
      root_head_in.root = '0;
      root_head_in.ax   = ax_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         root_ff[0] <= root_head_in;
      end
   end

   for (genvar j = 0; j < 33; j++) begin : g_root
      localparam int B = 32 - j;
      logic [66:0] trial;
      logic        take;

      assign trial = ({34'd0, root_ff[j].root} << (B + 1))
                   | ({{66{1'b0}}, 1'b1} << (2 * B));
      assign take  = {1'b0, root_ff[j].rem} >= trial;

      always_comb begin
         root_in[j] = root_ff[j];
         if (take) begin
            root_in[j].rem  = root_ff[j].rem - trial[65:0];
            root_in[j].root = root_ff[j].root | (33'd1 << B);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[j+1] <= root_in[j];
         end
      end
   end

   // ---------------------------------------------------------------
   // stage 36: stretch e = l - rest, its magnitude and the flags
   // ---------------------------------------------------------------
   len_stage_type len_ff;
   len_stage_type len_in;
   logic [33:0]   stretch;

   always_comb begin
      stretch         = {1'b0, root_ff[33].root} - {3'b000, rest_ff};
      len_in.len      = root_ff[33].root;
      len_in.eneg     = stretch[33];
      len_in.emag     = stretch[33] ? 33'(~stretch + 34'd1) : stretch[32:0];
      len_in.slack    = bungee_ff && stretch[33];
      len_in.zero_len = (root_ff[33].root == '0);
      len_in.ax       = root_ff[33].ax;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         len_ff <= len_in;
      end
   end

   // ---------------------------------------------------------------
   // stages 37-38: ke = k * |e|, split on |e| at bit 17
   // ---------------------------------------------------------------
   kmul_stage_type km_ff;
   kmul_stage_type km_in;
   ke_stage_type   ke_ff;
   ke_stage_type   ke_in;

   always_comb begin
      km_in.p_lo = 48'(spring_k_ff) * 48'(len_ff.emag[16:0]);
      km_in.p_hi = 47'(spring_k_ff) * 47'(len_ff.emag[32:17]);
      km_in.ls   = len_ff;
      ke_in.ke   = 64'(km_ff.p_lo) + (64'(km_ff.p_hi) << 17);
      ke_in.ls   = km_ff.ls;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         km_ff <= km_in;
         ke_ff <= ke_in;
      end
   end

   // ---------------------------------------------------------------
   // stages 39-40: N = ke * |d_i|, split on ke at bit 32; keep N >> 16
   // so the divisor is l rather than l * 2^16
   // ---------------------------------------------------------------
   nmul_stage_type nm_ff;
   nmul_stage_type nm_in;
   num_stage_type  num_ff;
   num_stage_type  num_in;
   logic [2:0][96:0] num_full;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nm_in.p0[i]  = 65'(ke_ff.ke[31:0])  * 65'(ke_ff.ls.ax.mag[i]);
         nm_in.p1[i]  = 65'(ke_ff.ke[63:32]) * 65'(ke_ff.ls.ax.mag[i]);
         // force points against d when stretched, along d when compressed
         nm_in.neg[i] = (ke_ff.ls.eneg == ke_ff.ls.ax.dneg[i]);
      end
      nm_in.len      = ke_ff.ls.len;
      nm_in.slack    = ke_ff.ls.slack;
      nm_in.zero_len = ke_ff.ls.zero_len;

      for (int i = 0; i < 3; i++) begin
         num_full[i]   = 97'(nm_ff.p0[i]) + (97'(nm_ff.p1[i]) << 32);
         num_in.num[i] = num_full[i][96:16];
      end
      num_in.len      = nm_ff.len;
      num_in.neg      = nm_ff.neg;
      num_in.slack    = nm_ff.slack;
      num_in.zero_len = nm_ff.zero_len;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nm_ff  <= nm_in;
         num_ff <= num_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 41: divider setup. A quotient of 2^32 or more saturates in
   // either direction, so flag it here; otherwise the upper part is
   // already below l and seeds the remainder.
   // ---------------------------------------------------------------
   div_stage_type div_ff [33];
   div_stage_type div_in [32];
   div_stage_type div_head_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         div_head_in.over[i] = num_ff.num[i][80:32] >= {16'd0, num_ff.len};
         div_head_in.rem[i]  = num_ff.num[i][64:32];
         div_head_in.qn[i]   = num_ff.num[i][31:0];
      end
      div_head_in.len      = num_ff.len;
      div_head_in.neg      = num_ff.neg;
      div_head_in.slack    = num_ff.slack;
      div_head_in.zero_len = num_ff.zero_len;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff[0] <= div_head_in;
      end
   end

   // restoring divider: shift a dividend bit out of qn, a quotient bit in
   for (genvar j = 0; j < 32; j++) begin : g_div
      logic [2:0][33:0] part;
      logic [2:0]       ge;

      always_comb begin
         div_in[j] = div_ff[j];
         for (int i = 0; i < 3; i++) begin
            part[i] = {div_ff[j].rem[i], div_ff[j].qn[i][31]};
            ge[i]   = part[i] >= {1'b0, div_ff[j].len};
            div_in[j].rem[i] = ge[i] ? 33'(part[i] - {1'b0, div_ff[j].len})
                                     : part[i][32:0];
            div_in[j].qn[i]  = {div_ff[j].qn[i][30:0], ge[i]};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            div_ff[j+1] <= div_in[j];
         end
      end
   end

   // ---------------------------------------------------------------
   // output register: sign, saturate, zero-length and slack cases
   // ---------------------------------------------------------------
   logic [2:0][31:0] force_ff;
   logic [2:0][31:0] force_in;
   logic             applied_ff;
   logic             applied_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (div_ff[32].slack || div_ff[32].zero_len) begin
            force_in[i] = '0;
         end else if (div_ff[32].qn[i] == '0 && !div_ff[32].over[i]) begin
            force_in[i] = '0;
         end else if (div_ff[32].neg[i]) begin
            // saturate at the most negative value
            if (div_ff[32].over[i] || div_ff[32].qn[i] > 32'h8000_0000) begin
               force_in[i] = 32'h8000_0000;
            end else begin
               force_in[i] = ~div_ff[32].qn[i] + 32'd1;
            end
         end else begin
            if (div_ff[32].over[i] || div_ff[32].qn[i][31]) begin
               force_in[i] = 32'h7FFF_FFFF;
            end else begin
               force_in[i] = div_ff[32].qn[i];
            end
         end
      end
      applied_in = !div_ff[32].slack;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_take) begin
         rsp_valid_ff <= v_ff[NStage-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         force_ff   <= force_in;
         applied_ff <= applied_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_force_x = force_ff[0];
   assign rsp_force_y = force_ff[1];
   assign rsp_force_z = force_ff[2];
   assign rsp_applied = applied_ff;

`ifndef SYNTHESIS
   // a slack bungee never reports a force
   a_slack_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !applied_ff) |-> (force_ff == '0))
      else $error("slack result carries a nonzero force");

   // slack is only possible in bungee mode
   a_slack_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !applied_ff) |-> bungee_ff)
      else $error("applied cleared outside bungee mode");

   // a finished item blocked by a full, stalled output stays in place
   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && v_ff[NStage-1]) |=> v_ff[NStage-1])
      else $error("last pipeline stage dropped a held beat");

   // the root step range and divider setup sit where the stage map says
   a_stage_map: assert property (@(posedge clock) disable iff (reset)
      (en && v_ff[RootBase] && v_ff[DivBase]) |=> (v_ff[RootBase+1] && v_ff[DivBase+1]))
      else $error("valid bit lost inside the pipeline");
`endif

endmodule
